// File: design/rbrb_pkg.sv
// Package for the ReLU relaxation backward block: constants and field widths.
// No dependencies.
package rbrb_pkg;
    localparam int NEURON_COUNT_DEF  = 256;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int INDEX_W           = 8;
    localparam int DATA_W            = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_COEFF = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_BIAS,
        ST_WRITE
    } load_state_t;
endpackage

// File: design/relu_bound_relaxation_backward.sv
// Top level of the ReLU relaxation backward block.
// Depends on rbrb_pkg.
//
// channel  dir  payload
// s_axis   in   tdata {upper_coeff,lower_coeff,upper_bound,lower_bound,neuron_index}, tuser op,
//               tlast row_end
// m_axis   out  tdata {upper_bias_sum,lower_bias_sum,new_upper_coeff,new_lower_coeff},
//               tuser saturated, tlast row_done
//
// Coefficient beats: table read, then multiply and register.
// Dead or active bound loads: accept, then table write. Uncertain loads: accept,
// restoring division of FRACTION_BITS+1 quotient bits, then bias and write.
// The relaxation tables live in one synchronous memory; one beat is in work at a time.
// Reset clears control and the row accumulators; table contents stay undefined.
// A full output register stalls the input side.
module relu_bound_relaxation_backward #(
    parameter int NEURON_COUNT  = rbrb_pkg::NEURON_COUNT_DEF,
    parameter int FRACTION_BITS = rbrb_pkg::FRACTION_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // bits: neuron_index[7:0], lower_bound[39:8], upper_bound[71:40],
    // lower_coeff[103:72], upper_coeff[135:104]
    input  logic [135:0] s_axis_tdata,
    input  logic         s_axis_tuser,   // operation
    input  logic         s_axis_tlast,   // row_end
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bits: new_lower_coeff[31:0], new_upper_coeff[63:32],
    // lower_bias_sum[95:64], upper_bias_sum[127:96]
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tuser,   // saturated
    output logic         m_axis_tlast    // row_done
);
    localparam int SW    = FRACTION_BITS + 1;
    localparam int EW    = 1 + SW + rbrb_pkg::DATA_W;
    localparam int AW    = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
    localparam int CW    = $clog2(FRACTION_BITS + 2);
    localparam int ONE   = 1 << FRACTION_BITS;
    localparam int HALF  = 1 << (FRACTION_BITS - 1);

    localparam logic [1:0] KIND_DEAD      = 2'd0;
    localparam logic [1:0] KIND_ACTIVE    = 2'd1;
    localparam logic [1:0] KIND_UNCERTAIN = 2'd2;

    // stored entry: {lower slope, upper slope, upper bias}
    logic [EW-1:0] mem [NEURON_COUNT];
    logic [EW-1:0] rd_data;

    logic [rbrb_pkg::INDEX_W-1:0] in_idx;
    logic signed [31:0] in_l, in_u, in_alo, in_aup;
    assign in_idx = s_axis_tdata[7:0];
    assign in_l   = s_axis_tdata[39:8];
    assign in_u   = s_axis_tdata[71:40];
    assign in_alo = s_axis_tdata[103:72];
    assign in_aup = s_axis_tdata[135:104];

    logic in_range;
    assign in_range = ({24'd0, in_idx} < 32'(NEURON_COUNT));

    rbrb_pkg::load_state_t st_reg, st_next;
    logic        cf_valid_reg;           // coefficient beat waiting on memory read
    logic        cf_range_reg, cf_last_reg;
    logic signed [31:0] cf_alo_reg, cf_aup_reg;
    logic [AW-1:0] addr_reg;
    logic signed [32:0] negl_reg;        // -l for uncertain loads
    logic [33+FRACTION_BITS:0] rem_reg;
    logic [32:0] den_reg;
    logic [SW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic signed [31:0] ub_reg;
    logic [1:0]  kind_reg;

    logic out_free;
    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = (st_reg == rbrb_pkg::ST_IDLE) && !cf_valid_reg && out_free;

    logic acc_in;
    assign acc_in = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            rbrb_pkg::ST_IDLE:
                if (acc_in && s_axis_tuser == rbrb_pkg::OP_LOAD && in_range)
                    st_next = (in_u > 0 && in_l < 0) ? rbrb_pkg::ST_DIV : rbrb_pkg::ST_WRITE;
            rbrb_pkg::ST_DIV:
                if (cnt_reg == CW'(0)) st_next = rbrb_pkg::ST_BIAS;
            rbrb_pkg::ST_BIAS:  st_next = rbrb_pkg::ST_WRITE;
            rbrb_pkg::ST_WRITE: st_next = rbrb_pkg::ST_IDLE;
            default:            st_next = rbrb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= rbrb_pkg::ST_IDLE;
        else
            st_reg <= st_next;
    end

    // restoring division: quotient bit per cycle, FRACTION_BITS+1 bits total
    logic [33+FRACTION_BITS:0] trial;
    assign trial = rem_reg - ({{(FRACTION_BITS+1){1'b0}}, den_reg} << cnt_reg);
    logic signed [33+SW:0] bias_prod;
    assign bias_prod = $signed({1'b0, quo_reg}) * negl_reg;

    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            addr_reg <= AW'(in_idx);
            negl_reg <= -33'(in_l);
            rem_reg  <= (34+FRACTION_BITS)'(in_u) << FRACTION_BITS;
            den_reg  <= 33'(in_u) - 33'(in_l);
            quo_reg  <= '0;
            cnt_reg  <= CW'(FRACTION_BITS);
            ub_reg   <= '0;
            kind_reg <= (in_u <= 0) ? KIND_DEAD : (in_l >= 0) ? KIND_ACTIVE : KIND_UNCERTAIN;
        end
        else if (st_reg == rbrb_pkg::ST_DIV)
        begin
            if (!trial[33+FRACTION_BITS])
            begin
                rem_reg <= trial;
                quo_reg[cnt_reg] <= 1'b1;
            end
            cnt_reg <= cnt_reg - CW'(1);
        end
        else if (st_reg == rbrb_pkg::ST_BIAS)
            ub_reg <= 32'(bias_prod >>> FRACTION_BITS);
    end

    // memory write and read
    logic [EW-1:0] wr_entry;
    always_comb
    begin
        case (kind_reg)
            KIND_ACTIVE:    wr_entry = {1'b1, SW'(ONE), 32'd0};
            KIND_UNCERTAIN: wr_entry = {(quo_reg > SW'(HALF)), quo_reg, ub_reg};
            default:        wr_entry = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == rbrb_pkg::ST_WRITE)
            mem[addr_reg] <= wr_entry;
        rd_data <= mem[AW'(in_idx)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cf_valid_reg <= 1'b0;
        else
            cf_valid_reg <= acc_in && s_axis_tuser == rbrb_pkg::OP_COEFF;
    end

    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            cf_range_reg <= in_range;
            cf_last_reg  <= s_axis_tlast;
            cf_alo_reg   <= in_alo;
            cf_aup_reg   <= in_aup;
        end
    end

    // coefficient compute
    logic            ls;
    logic [SW-1:0]   us;
    logic signed [31:0] ub;
    assign ls = cf_range_reg ? rd_data[EW-1] : 1'b0;
    assign us = cf_range_reg ? rd_data[EW-2 -: SW] : '0;
    assign ub = cf_range_reg ? rd_data[31:0] : '0;

    logic signed [32+SW:0] plo, pup;
    logic signed [63:0] blo, bup;
    assign plo = cf_alo_reg * $signed({1'b0, us});
    assign pup = cf_aup_reg * $signed({1'b0, us});
    assign blo = cf_alo_reg * ub;
    assign bup = cf_aup_reg * ub;

    logic signed [31:0] new_lo, new_up;
    logic signed [63:0] bsh_lo, bsh_up;
    logic signed [31:0] c_lo, c_up, nacc_lo, nacc_up;
    logic signed [32:0] s_lo, s_up;
    logic               sat;
    logic signed [31:0] acc_lo_reg, acc_up_reg;
    logic               sat_reg;

    always_comb
    begin
        sat    = 1'b0;
        bsh_lo = blo >>> FRACTION_BITS;
        bsh_up = bup >>> FRACTION_BITS;
        c_lo = 32'(bsh_lo);
        c_up = 32'(bsh_up);
        nacc_lo = acc_lo_reg;
        nacc_up = acc_up_reg;
        s_lo = '0;
        s_up = '0;
        if (!cf_alo_reg[31])
            new_lo = ls ? cf_alo_reg : 32'sd0;
        else
        begin
            new_lo = 32'(plo >>> FRACTION_BITS);
            if (bsh_lo > 64'sh7FFFFFFF) begin c_lo = 32'h7FFFFFFF; sat = 1'b1; end
            else if (bsh_lo < -64'sh80000000) begin c_lo = 32'h80000000; sat = 1'b1; end
            s_lo = 33'(acc_lo_reg) + 33'(c_lo);
            if (s_lo[32] != s_lo[31])
            begin
                nacc_lo = s_lo[32] ? 32'h80000000 : 32'h7FFFFFFF;
                sat = 1'b1;
            end
            else nacc_lo = s_lo[31:0];
        end
        if (!cf_aup_reg[31])
        begin
            new_up = 32'(pup >>> FRACTION_BITS);
            if (bsh_up > 64'sh7FFFFFFF) begin c_up = 32'h7FFFFFFF; sat = 1'b1; end
            else if (bsh_up < -64'sh80000000) begin c_up = 32'h80000000; sat = 1'b1; end
            s_up = 33'(acc_up_reg) + 33'(c_up);
            if (s_up[32] != s_up[31])
            begin
                nacc_up = s_up[32] ? 32'h80000000 : 32'h7FFFFFFF;
                sat = 1'b1;
            end
            else nacc_up = s_up[31:0];
        end
        else
            new_up = ls ? cf_aup_reg : 32'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_lo_reg    <= '0;
            acc_up_reg    <= '0;
            sat_reg       <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (cf_valid_reg)
            begin
                m_axis_tvalid <= 1'b1;
                acc_lo_reg <= cf_last_reg ? 32'sd0 : nacc_lo;
                acc_up_reg <= cf_last_reg ? 32'sd0 : nacc_up;
                sat_reg    <= cf_last_reg ? 1'b0 : (sat_reg | sat);
            end
            else if (m_axis_tready)
                m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cf_valid_reg)
        begin
            m_axis_tdata <= {cf_last_reg ? nacc_up : 32'd0, cf_last_reg ? nacc_lo : 32'd0,
                             new_up, new_lo};
            m_axis_tlast <= cf_last_reg;
            m_axis_tuser <= sat_reg | sat;
        end
    end
endmodule

// File: tb/relu_relax_checker.sv
// Checker for the ReLU relaxation backward block: watches both stream channels,
// predicts results from accepted input beats and compares them. Depends on rbrb_pkg.
`timescale 1ns / 100ps

module relu_relax_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [127:0] m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         m_axis_tlast,
    output int           fail_count,
    output int           pending_count,
    output int           rows_seen
);
    localparam int FB = rbrb_pkg::FRACTION_BITS_DEF;
    localparam longint ONE_Q = longint'(1) << FB;

    typedef struct packed {
        logic [31:0] new_lo;
        logic [31:0] new_up;
        logic [31:0] lo_sum;
        logic [31:0] up_sum;
        logic        done;
        logic        sat;
    } relax_result_t;

    relax_result_t result_q[$];
    bit            lo_slope_mem[rbrb_pkg::NEURON_COUNT_DEF];
    longint        up_slope_mem[rbrb_pkg::NEURON_COUNT_DEF];
    longint        up_bias_mem[rbrb_pkg::NEURON_COUNT_DEF];
    longint        lo_acc, up_acc;
    bit            row_sat;

    assign pending_count = result_q.size();

    function automatic longint floor_q(longint x);
        return x >>> FB;   // arithmetic shift is floor
    endfunction

    function automatic longint sat32(longint x, inout bit sat);
        if (x > 64'sd2147483647) begin sat = 1; return 64'sd2147483647; end
        if (x < -64'sd2147483648) begin sat = 1; return -64'sd2147483648; end
        return x;
    endfunction

    task automatic relax_update(logic [135:0] d, logic op, logic last);
        int     idx;
        longint l, u, a_lo, a_up, us, ub, contrib, new_lo, new_up;
        bit     ls, sat;
        relax_result_t r;
        idx = d[7:0];
        if (op == rbrb_pkg::OP_LOAD) begin
            l = longint'($signed(d[39:8]));
            u = longint'($signed(d[71:40]));
            ls = 0; us = 0; ub = 0;
            if (u <= 0) begin
            end else if (l >= 0) begin
                ls = 1; us = ONE_Q;
            end else begin
                us = (u << FB) / (u - l);
                ub = (us * (-l)) >>> FB;
                ls = us > (ONE_Q >> 1);
            end
            lo_slope_mem[idx] = ls;
            up_slope_mem[idx] = us;
            up_bias_mem[idx] = ub;
            return;
        end
        a_lo = longint'($signed(d[103:72]));
        a_up = longint'($signed(d[135:104]));
        ls = lo_slope_mem[idx]; us = up_slope_mem[idx]; ub = up_bias_mem[idx];
        sat = 0;
        if (a_lo >= 0) new_lo = ls ? a_lo : 0;
        else begin
            new_lo = floor_q(a_lo * us);
            contrib = sat32(floor_q(a_lo * ub), sat);
            lo_acc = sat32(lo_acc + contrib, sat);
        end
        if (a_up >= 0) begin
            new_up = floor_q(a_up * us);
            contrib = sat32(floor_q(a_up * ub), sat);
            up_acc = sat32(up_acc + contrib, sat);
        end else new_up = ls ? a_up : 0;
        if (sat) row_sat = 1;
        r.new_lo = new_lo[31:0];
        r.new_up = new_up[31:0];
        r.lo_sum = last ? lo_acc[31:0] : 32'd0;
        r.up_sum = last ? up_acc[31:0] : 32'd0;
        r.done = last;
        r.sat = row_sat;
        result_q.push_back(r);
        if (last) begin
            lo_acc = 0; up_acc = 0; row_sat = 0;
        end
    endtask

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d actual %0d", name, $signed(exp_v),
                   $signed(act_v));
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0; rows_seen = 0;
        lo_acc = 0; up_acc = 0; row_sat = 0;
    end

    always @(posedge clk) begin
        relax_result_t e;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result beat");
                    fail_count++;
                end else begin
                    e = result_q.pop_front();
                    compare_field("new_lower_coeff", e.new_lo, m_axis_tdata[31:0]);
                    compare_field("new_upper_coeff", e.new_up, m_axis_tdata[63:32]);
                    compare_field("lower_bias_sum", e.lo_sum, m_axis_tdata[95:64]);
                    compare_field("upper_bias_sum", e.up_sum, m_axis_tdata[127:96]);
                    compare_field("row_done", {31'd0, e.done}, {31'd0, m_axis_tlast});
                    compare_field("saturated", {31'd0, e.sat}, {31'd0, m_axis_tuser});
                    if (m_axis_tlast) rows_seen++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                relax_update(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        end
    end
endmodule

// File: tb/tb_relu_bound_relaxation_backward.sv
// Testbench top for relu_bound_relaxation_backward: drives bound loads and coefficient
// rows with random gaps and stalls. Depends on rbrb_pkg, the DUT and relu_relax_checker.
`timescale 1ns / 100ps

module tb_relu_bound_relaxation_backward;
    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 0;
    logic         s_axis_tlast = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    int           fail_count, pending_count, rows_seen;
    int           loads_sent, coeffs_sent;
    bit           loaded[rbrb_pkg::NEURON_COUNT_DEF];

    always #5 clk = ~clk;

    relu_bound_relaxation_backward dut (.*);
    relu_relax_checker checker_i (.*);

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // edge-heavy random Q16.16 value
    function automatic logic [31:0] pick_val();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
        endcase
    endfunction

    // valid stays high into the next beat when there is no gap
    task automatic send_beat(logic op, logic [7:0] idx, logic [31:0] a, logic [31:0] b,
                             logic last);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tlast <= last;
        if (op == rbrb_pkg::OP_LOAD) begin
            s_axis_tdata <= {$urandom, $urandom, b, a, idx};
            loaded[idx] = 1;
            loads_sent++;
        end else begin
            s_axis_tdata <= {b, a, $urandom, $urandom, idx};
            coeffs_sent++;
        end
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pick_loaded(output logic [7:0] idx);
        do idx = 8'($urandom_range(0, 255)); while (!loaded[idx]);
    endtask

    // receiver stalls
    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 29) == 0) begin
                m_axis_tready <= 0;
                repeat ($urandom_range(5, 30)) @(negedge clk);
            end else m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [7:0] idx;
        int n, w;
        loads_sent = 0; coeffs_sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // directed: active, dead, crossed, uncertain near half, extremes
        send_beat(rbrb_pkg::OP_LOAD, 8'd0, 32'h0001_0000, 32'h0002_0000, 1'b0);
        send_beat(rbrb_pkg::OP_LOAD, 8'd1, 32'hFFFF_0000, 32'hFFFF_8000, 1'b0);
        send_beat(rbrb_pkg::OP_LOAD, 8'd2, 32'h0001_0000, 32'h0000_0000, 1'b0);
        send_beat(rbrb_pkg::OP_LOAD, 8'd3, 32'hFFFF_0000, 32'h0001_0000, 1'b0);
        send_beat(rbrb_pkg::OP_LOAD, 8'd4, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_beat(rbrb_pkg::OP_LOAD, 8'd5, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        send_beat(rbrb_pkg::OP_LOAD, 8'd6, 32'h8000_0000, 32'h0000_0001, 1'b0);
        send_beat(rbrb_pkg::OP_LOAD, 8'd255, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        for (int i = 0; i < 8; i++)
            send_beat(rbrb_pkg::OP_COEFF, (i == 7) ? 8'd255 : 8'(i), 32'h8000_0000,
                      32'h7FFF_FFFF, 1'b0);
        send_beat(rbrb_pkg::OP_COEFF, 8'd4, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_beat(rbrb_pkg::OP_COEFF, 8'd6, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_beat(rbrb_pkg::OP_COEFF, 8'd4, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_beat(rbrb_pkg::OP_COEFF, 8'd0, 32'd0, 32'd0, 1'b1);
        // random: mostly rows over loaded neurons, some fresh loads
        while (loads_sent + coeffs_sent < 1300) begin
            if ($urandom_range(0, 3) == 0) begin
                send_beat(rbrb_pkg::OP_LOAD, 8'($urandom), pick_val(), pick_val(),
                          1'($urandom));
            end else begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
                for (int k = 0; k < n; k++) begin
                    pick_loaded(idx);
                    send_beat(rbrb_pkg::OP_COEFF, idx, pick_val(), pick_val(), k == n - 1);
                end
            end
        end
        s_axis_tvalid <= 0;
        w = 0;
        while (pending_count != 0 && w < 100000) begin
            @(posedge clk);
            w++;
        end
        repeat (20) @(posedge clk);
        $display("Sent %0d bound loads and %0d coefficient beats; %0d rows completed.",
                 loads_sent, coeffs_sent, rows_seen);
        if (fail_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
